// File: src/current_load_regulator_macros.svh
// Assertion macros used by the regulator core.
`ifndef CURRENT_LOAD_REGULATOR_MACROS_SVH
`define CURRENT_LOAD_REGULATOR_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CLR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/clr_pkg.sv
// Shared types, codes and constants of the current load regulator.
package clr_pkg;

    // Field widths.
    localparam int OP_W         = 2;
    localparam int SAMPLE_W     = 10;
    localparam int SETPOINT_W   = 16;
    localparam int GAIN_W       = 16;
    localparam int DUTY_W       = 10;
    localparam int LEVEL_W      = 22;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Scaling: Q8 gain product and the milliamp value taken from it.
    localparam int GAIN_FRAC_W  = 8;
    localparam int PROD_W       = SAMPLE_W + GAIN_W;
    localparam int MA_W         = PROD_W - GAIN_FRAC_W;

    // Reciprocal shift used to split a sample by a window length.
    localparam int RECIP_SHIFT  = 20;

    // Widest remainders over the allowed window lengths.
    localparam int OFF_REM_MAX_W = 6;
    localparam int MEA_REM_MAX_W = 7;

    // Window lengths.
    localparam int OFFSET_SAMPLES_DEF  = 50;
    localparam int MEASURE_SAMPLES_DEF = 126;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CAL  = 2'd0;
    localparam logic [OP_W-1:0] OP_MEAS = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX     = 2'd2;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd12512;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 10'd1023;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [SAMPLE_W-1:0]   sample;
        logic                  run_enable;
        logic [SETPOINT_W-1:0] setpoint;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty_out;
        logic [LEVEL_W-1:0]  measured_value;
        logic [SAMPLE_W-1:0] offset_raw;
        logic                window_done;
    } t_out_item;

    typedef struct packed {
        logic              power_mode;
        logic [GAIN_W-1:0] current_gain;
        logic [DUTY_W-1:0] duty_max;
    } t_cfg;

    // Input register contents: the item with its sample split per window.
    typedef struct packed {
        logic                     valid;
        logic [OP_W-1:0]          operation;
        logic                     run_enable;
        logic [SETPOINT_W-1:0]    setpoint;
        logic [SAMPLE_W-1:0]      off_quo;
        logic [OFF_REM_MAX_W-1:0] off_rem;
        logic [SAMPLE_W-1:0]      mea_quo;
        logic [MEA_REM_MAX_W-1:0] mea_rem;
    } t_split;

endpackage

// File: src/clr_in_if.sv
// Input channel carrying one regulator item per beat.
interface clr_in_if;
    logic              valid;
    logic              ready;
    clr_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/clr_out_if.sv
// Output channel carrying one regulator result per beat.
interface clr_out_if;
    logic               valid;
    logic               ready;
    clr_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/current_load_regulator.sv
// Top level of the current load regulator.
//
//  Channel    Dir  Beat / write
//  i_item     in   operation, sample, run_enable, setpoint
//  o_result   out  duty_out, measured_value, offset_raw, window_done
//  i_cfg_*    in   register index and data, taken when i_cfg_we is high
//
// One item per cycle while the result is not stalled, window ends included; a
// result is valid once its item has passed the input register, then the result register.
// The window sums are split at the input register so that the core adds,
// scales with one gain multiply and steps the duty in the same cycle.
// Reset sets configuration to its defaults and clears all state but the payloads.
// While a result stalls, the input register still takes one more beat.
module current_load_regulator #(
    parameter int OFFSET_SAMPLES  = clr_pkg::OFFSET_SAMPLES_DEF,
    parameter int MEASURE_SAMPLES = clr_pkg::MEASURE_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    clr_in_if.sink                          i_item,
    clr_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    clr_pkg::t_cfg   cfg;
    clr_pkg::t_split stage;
    logic            take;

    clr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    clr_split #(
        .OFFSET_SAMPLES  (OFFSET_SAMPLES),
        .MEASURE_SAMPLES (MEASURE_SAMPLES)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (take),
        .o_stage (stage)
    );

    clr_core #(
        .OFFSET_SAMPLES  (OFFSET_SAMPLES),
        .MEASURE_SAMPLES (MEASURE_SAMPLES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (stage),
        .i_cfg    (cfg),
        .o_take   (take),
        .o_result (o_result)
    );

endmodule

// File: src/clr_cfg.sv
// Configuration registers of the regulator with their write decode.
module clr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output clr_pkg::t_cfg                    o_cfg
);

    clr_pkg::t_cfg r_cfg;

    // Decode the register index; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_mode   <= 1'b0;
            r_cfg.current_gain <= clr_pkg::GAIN_RESET;
            r_cfg.duty_max     <= clr_pkg::DUTY_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clr_pkg::CFG_POWER_MODE: begin
                    r_cfg.power_mode <= i_cfg_data[0];
                end
                clr_pkg::CFG_CURRENT_GAIN: begin
                    r_cfg.current_gain <= i_cfg_data[clr_pkg::GAIN_W-1:0];
                end
                clr_pkg::CFG_DUTY_MAX: begin
                    r_cfg.duty_max <= i_cfg_data[clr_pkg::DUTY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/clr_split.sv
// Input register that splits each sample into quotient and remainder per window.
module clr_split #(
    parameter int OFFSET_SAMPLES  = clr_pkg::OFFSET_SAMPLES_DEF,
    parameter int MEASURE_SAMPLES = clr_pkg::MEASURE_SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    clr_in_if.sink          i_item,
    input  logic            i_take,
    output clr_pkg::t_split o_stage
);

    localparam int SampleW = clr_pkg::SAMPLE_W;
    localparam int Shift   = clr_pkg::RECIP_SHIFT;
    localparam int ProdW   = SampleW + Shift + 1;

    // Rounded-up reciprocals; exact for every 10-bit sample at this shift.
    localparam int OffRecipI = ((1 << Shift) + OFFSET_SAMPLES - 1) / OFFSET_SAMPLES;
    localparam int MeaRecipI = ((1 << Shift) + MEASURE_SAMPLES - 1) / MEASURE_SAMPLES;
    localparam logic [Shift:0]     OffRecip = OffRecipI[Shift:0];
    localparam logic [Shift:0]     MeaRecip = MeaRecipI[Shift:0];
    localparam logic [SampleW-1:0] OffN     = OFFSET_SAMPLES[SampleW-1:0];
    localparam logic [SampleW-1:0] MeaN     = MEASURE_SAMPLES[SampleW-1:0];

    clr_pkg::t_split      r_stage;
    logic [ProdW-1:0]     off_prod;
    logic [ProdW-1:0]     mea_prod;
    logic [SampleW-1:0]   off_quo;
    logic [SampleW-1:0]   mea_quo;
    logic [SampleW-1:0]   off_rem;
    logic [SampleW-1:0]   mea_rem;
    logic                 load;

    // Divide the incoming sample by each window length.
    always_comb begin
        off_prod = {{(Shift + 1){1'b0}}, i_item.data.sample} * {{SampleW{1'b0}}, OffRecip};
        mea_prod = {{(Shift + 1){1'b0}}, i_item.data.sample} * {{SampleW{1'b0}}, MeaRecip};
        off_quo  = off_prod[Shift +: SampleW];
        mea_quo  = mea_prod[Shift +: SampleW];
        off_rem  = i_item.data.sample - off_quo * OffN;
        mea_rem  = i_item.data.sample - mea_quo * MeaN;
    end

    // The register frees up whenever the core takes its beat.
    assign i_item.ready = !r_stage.valid || i_take;
    assign load         = i_item.ready && i_item.valid;

    // Valid flag under reset, payload loaded on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_item.ready) begin
            r_stage.valid <= i_item.valid;
        end
        if (load) begin
            r_stage.operation  <= i_item.data.operation;
            r_stage.run_enable <= i_item.data.run_enable;
            r_stage.setpoint   <= i_item.data.setpoint;
            r_stage.off_quo    <= off_quo;
            r_stage.off_rem    <= off_rem[clr_pkg::OFF_REM_MAX_W-1:0];
            r_stage.mea_quo    <= mea_quo;
            r_stage.mea_rem    <= mea_rem[clr_pkg::MEA_REM_MAX_W-1:0];
        end
    end

    assign o_stage = r_stage;

endmodule

// File: src/clr_core.sv
// Regulator core: window accumulation, scaling, duty stepping and the
// result register.
`include "current_load_regulator_macros.svh"

module clr_core #(
    parameter int OFFSET_SAMPLES  = clr_pkg::OFFSET_SAMPLES_DEF,
    parameter int MEASURE_SAMPLES = clr_pkg::MEASURE_SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clr_pkg::t_split i_stage,
    input  clr_pkg::t_cfg   i_cfg,
    output logic            o_take,
    clr_out_if.source       o_result
);

    localparam int SampleW = clr_pkg::SAMPLE_W;
    localparam int DutyW   = clr_pkg::DUTY_W;
    localparam int LevelW  = clr_pkg::LEVEL_W;
    localparam int ProdW   = clr_pkg::PROD_W;
    localparam int MaW     = clr_pkg::MA_W;
    localparam int OffW    = $clog2(OFFSET_SAMPLES + 1);
    localparam int MeaW    = $clog2(MEASURE_SAMPLES + 1);

    localparam logic [OffW-1:0] OffN  = OFFSET_SAMPLES[OffW-1:0];
    localparam logic [MeaW-1:0] MeaN  = MEASURE_SAMPLES[MeaW-1:0];
    localparam logic [OffW:0]   OffNx = OFFSET_SAMPLES[OffW:0];
    localparam logic [MeaW:0]   MeaNx = MEASURE_SAMPLES[MeaW:0];

    // Window state: running sum kept as quotient and remainder.
    logic [SampleW-1:0] r_off_quo, n_off_quo;
    logic [OffW-1:0]    r_off_rem, n_off_rem;
    logic [OffW-1:0]    r_off_cnt, n_off_cnt;
    logic [SampleW-1:0] r_off_avg, n_off_avg;
    logic [SampleW-1:0] r_mea_quo, n_mea_quo;
    logic [MeaW-1:0]    r_mea_rem, n_mea_rem;
    logic [MeaW-1:0]    r_mea_cnt, n_mea_cnt;
    logic [LevelW-1:0]  r_level, n_level;
    logic [DutyW-1:0]   r_duty, n_duty;

    logic               r_out_valid;
    clr_pkg::t_out_item r_out, n_out;

    logic [OffW:0]      off_rem_sum;
    logic               off_wrap;
    logic [OffW:0]      off_rem_adj;
    logic [SampleW-1:0] off_quo_sum;
    logic [OffW-1:0]    off_cnt_inc;
    logic [MeaW:0]      mea_rem_sum;
    logic               mea_wrap;
    logic [MeaW:0]      mea_rem_adj;
    logic [SampleW-1:0] mea_quo_sum;
    logic [MeaW-1:0]    mea_cnt_inc;
    logic [SampleW-1:0] diff;
    logic [ProdW-1:0]   prod;
    logic [MaW-1:0]     milliamps;
    logic [LevelW-1:0]  scaled;
    logic               done;

    assign o_take = i_stage.valid && (!r_out_valid || o_result.ready);

    // Add the split sample into both windows.
    always_comb begin
        off_rem_sum = {1'b0, r_off_rem} + {1'b0, i_stage.off_rem[OffW-1:0]};
        off_wrap    = off_rem_sum >= OffNx;
        off_rem_adj = off_wrap ? off_rem_sum - OffNx : off_rem_sum;
        off_quo_sum = r_off_quo + i_stage.off_quo + {{(SampleW - 1){1'b0}}, off_wrap};
        off_cnt_inc = r_off_cnt + 1'b1;

        mea_rem_sum = {1'b0, r_mea_rem} + {1'b0, i_stage.mea_rem[MeaW-1:0]};
        mea_wrap    = mea_rem_sum >= MeaNx;
        mea_rem_adj = mea_wrap ? mea_rem_sum - MeaNx : mea_rem_sum;
        mea_quo_sum = r_mea_quo + i_stage.mea_quo + {{(SampleW - 1){1'b0}}, mea_wrap};
        mea_cnt_inc = r_mea_cnt + 1'b1;
    end

    // Scale the finished measurement average against the offset.
    always_comb begin
        diff      = (mea_quo_sum >= r_off_avg) ? mea_quo_sum - r_off_avg
                                               : r_off_avg - mea_quo_sum;
        prod      = {{clr_pkg::GAIN_W{1'b0}}, diff} * {{SampleW{1'b0}}, i_cfg.current_gain};
        milliamps = prod[ProdW-1:clr_pkg::GAIN_FRAC_W];
        if (i_cfg.power_mode) begin
            // Times twelve as eight plus four.
            scaled = {1'b0, milliamps, 3'b000} + {2'b00, milliamps, 2'b00};
        end else begin
            scaled = {{(LevelW - MaW){1'b0}}, milliamps};
        end
    end

    // Next state and result for the item in the input register.
    always_comb begin
        n_off_quo = r_off_quo;
        n_off_rem = r_off_rem;
        n_off_cnt = r_off_cnt;
        n_off_avg = r_off_avg;
        n_mea_quo = r_mea_quo;
        n_mea_rem = r_mea_rem;
        n_mea_cnt = r_mea_cnt;
        n_level   = r_level;
        n_duty    = r_duty;
        done      = 1'b0;
        n_out.duty_out = '0;

        case (i_stage.operation)
            clr_pkg::OP_CAL: begin
                if (off_cnt_inc == OffN) begin
                    n_off_avg = off_quo_sum;
                    n_off_quo = '0;
                    n_off_rem = '0;
                    n_off_cnt = '0;
                    done      = 1'b1;
                end else begin
                    n_off_quo = off_quo_sum;
                    n_off_rem = off_rem_adj[OffW-1:0];
                    n_off_cnt = off_cnt_inc;
                end
            end
            clr_pkg::OP_MEAS: begin
                if (mea_cnt_inc == MeaN) begin
                    n_level   = scaled;
                    n_mea_quo = '0;
                    n_mea_rem = '0;
                    n_mea_cnt = '0;
                    done      = 1'b1;
                end else begin
                    n_mea_quo = mea_quo_sum;
                    n_mea_rem = mea_rem_adj[MeaW-1:0];
                    n_mea_cnt = mea_cnt_inc;
                end
            end
            clr_pkg::OP_TICK: begin
                if (i_stage.run_enable) begin
                    if ({{(LevelW - clr_pkg::SETPOINT_W){1'b0}}, i_stage.setpoint} > r_level) begin
                        if (r_duty != '0) begin
                            n_duty = r_duty - 1'b1;
                        end
                    end else if (r_duty < i_cfg.duty_max) begin
                        n_duty = r_duty + 1'b1;
                    end
                    n_out.duty_out = n_duty;
                end
            end
            default: begin
            end
        endcase

        n_out.measured_value = n_level;
        n_out.offset_raw     = n_off_avg;
        n_out.window_done    = done;
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_quo   <= '0;
            r_off_rem   <= '0;
            r_off_cnt   <= '0;
            r_off_avg   <= '0;
            r_mea_quo   <= '0;
            r_mea_rem   <= '0;
            r_mea_cnt   <= '0;
            r_level     <= '0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_off_quo <= n_off_quo;
                r_off_rem <= n_off_rem;
                r_off_cnt <= n_off_cnt;
                r_off_avg <= n_off_avg;
                r_mea_quo <= n_mea_quo;
                r_mea_rem <= n_mea_rem;
                r_mea_cnt <= n_mea_cnt;
                r_level   <= n_level;
                r_duty    <= n_duty;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    `CLR_ASSERT_ALWAYS(a_off_rem_range, r_off_rem < OffN, "offset remainder out of range")
    `CLR_ASSERT_ALWAYS(a_mea_rem_range, r_mea_rem < MeaN, "measure remainder out of range")
    `CLR_ASSERT_NEXT(a_window_clears, o_take && done, (r_off_cnt == '0 && r_off_quo == '0 && r_off_rem == '0) || (r_mea_cnt == '0 && r_mea_quo == '0 && r_mea_rem == '0), "window end did not clear its sum")
    `CLR_ASSERT_NEXT(a_stopped_tick, o_take && i_stage.operation == clr_pkg::OP_TICK && !i_stage.run_enable, $stable(r_duty) && r_out.duty_out == '0, "stopped tick moved the duty")

endmodule
